[rtl/bpe_pkg.sv]
// Shared types and constants for the button and encoder event block.
package bpe_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int COUNT_WIDTH = 16;
    localparam int TIMER_W     = 16;
    localparam int STEP_W      = 8;
    localparam int STATUS_W    = 4;
    localparam int ROT_W       = 2;
    localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_STEP   = 2'd2;

    localparam logic [TIMER_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] LOCKOUT_RST    = 16'd50;
    localparam logic [STEP_W-1:0]  ENC_STEP_RST   = 8'd4;

    // Rotation codes.
    localparam logic [ROT_W-1:0] ROT_NONE  = 2'd0;
    localparam logic [ROT_W-1:0] ROT_LEFT  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_RIGHT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_NONE = 4'd0;

    typedef struct packed {
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] lockout_ticks;
        logic [STEP_W-1:0]  encoder_step;
    } cfg_t;

    typedef struct packed {
        logic                event_pending;
        logic [STATUS_W-1:0] button_status;
        logic [ROT_W-1:0]    rotation;
    } result_t;

endpackage

[rtl/bpe_core.sv]
// Per-tick state update: button edges, lockout and hold timers, encoder detents.
module bpe_core
    import bpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [NUM_BUTTONS-1:0] button_levels,
    input  logic [COUNT_WIDTH-1:0] encoder_count,
    input  logic                   clear_event,
    input  logic                   clear_status,
    input  logic                   clear_rotation,
    input  cfg_t                   cfg,
    output result_t                result
);

    logic [NUM_BUTTONS-1:0] prev_levels_reg, prev_levels_next;
    logic [NUM_BUTTONS-1:0] awaiting_reg, awaiting_next;
    logic [TIMER_W-1:0]     lock_cnt_reg, lock_cnt_next;
    logic                   lock_exp_reg, lock_exp_next;
    logic [TIMER_W-1:0]     hold_cnt_reg, hold_cnt_next;
    logic                   hold_run_reg, hold_run_next;
    logic                   hold_hit_reg, hold_hit_next;
    logic [COUNT_WIDTH-1:0] enc_ref_reg, enc_ref_next;
    logic                   event_reg, event_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [ROT_W-1:0]       rot_reg, rot_next;

    logic [NUM_BUTTONS-1:0] cand;
    logic [NUM_BUTTONS-1:0] first;
    logic [IDX_W-1:0]       sel_idx;
    logic [5:0]             idx6;
    logic                   edge_hit;
    logic                   is_press;
    logic                   is_release;
    logic [COUNT_WIDTH-1:0] diff;
    logic [COUNT_WIDTH-1:0] back;
    logic [COUNT_WIDTH-1:0] step_ext;

    // Press edge on press-armed buttons, release edge on release-armed ones.
    assign cand = (~awaiting_reg & prev_levels_reg & ~button_levels)
                | (awaiting_reg & ~prev_levels_reg & button_levels);
    assign first = cand & (~cand + 1'b1);

    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (first[i])
            begin
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    assign idx6       = 6'(sel_idx);
    assign edge_hit   = lock_exp_reg && (cand != '0);
    assign is_press   = edge_hit && ((awaiting_reg & first) == '0);
    assign is_release = edge_hit && !is_press;

    assign diff     = encoder_count - enc_ref_reg;
    assign back     = ~diff + 1'b1;
    assign step_ext = COUNT_WIDTH'(cfg.encoder_step);

    always_comb
    begin
        prev_levels_next = button_levels;
        awaiting_next    = awaiting_reg ^ (edge_hit ? first : '0);
        event_next       = clear_event ? 1'b0 : event_reg;
        status_next      = clear_status ? STATUS_NONE : status_reg;
        rot_next         = clear_rotation ? ROT_NONE : rot_reg;
        hold_hit_next    = hold_hit_reg;
        hold_cnt_next    = hold_cnt_reg;
        hold_run_next    = hold_run_reg;
        lock_cnt_next    = lock_cnt_reg;
        lock_exp_next    = lock_exp_reg;
        enc_ref_next     = enc_ref_reg;

        if (is_release)
        begin
            event_next = 1'b1;
            if (hold_hit_reg)
            begin
                hold_hit_next = 1'b0;
                status_next   = STATUS_W'(idx6 + idx6 + 6'd2);
            end
            else
            begin
                status_next = STATUS_W'(idx6 + idx6 + 6'd1);
            end
        end

        // Lockout timer: restart on any taken edge, else advance until expired.
        if (edge_hit)
        begin
            lock_cnt_next = '0;
            lock_exp_next = 1'b0;
        end
        else if (!lock_exp_reg)
        begin
            lock_cnt_next = (lock_cnt_reg == TIMER_MAX) ? TIMER_MAX : lock_cnt_reg + 1'b1;
            lock_exp_next = (lock_cnt_next >= cfg.lockout_ticks);
        end

        // Hold timer: restart on press, else advance while running.
        if (is_press)
        begin
            hold_cnt_next = '0;
            hold_run_next = 1'b1;
            hold_hit_next = 1'b0;
        end
        else if (hold_run_reg)
        begin
            hold_cnt_next = (hold_cnt_reg == TIMER_MAX) ? TIMER_MAX : hold_cnt_reg + 1'b1;
            if (hold_cnt_next >= cfg.long_press_ticks)
            begin
                hold_hit_next = 1'b1;
                hold_run_next = 1'b0;
            end
        end

        if (diff != '0)
        begin
            if (!diff[COUNT_WIDTH-1])
            begin
                if (diff >= step_ext)
                begin
                    rot_next     = ROT_RIGHT;
                    event_next   = 1'b1;
                    enc_ref_next = encoder_count;
                end
            end
            else if (back >= step_ext)
            begin
                rot_next     = ROT_LEFT;
                event_next   = 1'b1;
                enc_ref_next = encoder_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= '1;
            awaiting_reg    <= '0;
            lock_cnt_reg    <= '0;
            lock_exp_reg    <= 1'b0;
            hold_cnt_reg    <= '0;
            hold_run_reg    <= 1'b0;
            hold_hit_reg    <= 1'b0;
            enc_ref_reg     <= '0;
            event_reg       <= 1'b0;
            status_reg      <= STATUS_NONE;
            rot_reg         <= ROT_NONE;
        end
        else if (accept)
        begin
            prev_levels_reg <= prev_levels_next;
            awaiting_reg    <= awaiting_next;
            lock_cnt_reg    <= lock_cnt_next;
            lock_exp_reg    <= lock_exp_next;
            hold_cnt_reg    <= hold_cnt_next;
            hold_run_reg    <= hold_run_next;
            hold_hit_reg    <= hold_hit_next;
            enc_ref_reg     <= enc_ref_next;
            event_reg       <= event_next;
            status_reg      <= status_next;
            rot_reg         <= rot_next;
        end
    end

    assign result.event_pending = event_next;
    assign result.button_status = status_next;
    assign result.rotation      = rot_next;

endmodule

[rtl/bpe_out_q.sv]
// Two-entry result queue between the state update and the output channel.
module bpe_out_q
    import bpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop_ready,
    output logic    out_valid,
    output result_t out_data,
    output logic    full
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/button_press_hold_and_encoder_events.sv]
// Top level: button press/hold detector with edge lockout and encoder detent events.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, button_levels, encoder_count,| sink
//          | clear_event, clear_status, clear_rotation       |
//  out     | out_valid/out_ready, event_pending,             | source
//          | button_status, rotation                         |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | sink
//
// One tick per cycle while in_ready is high: state is updated at the input transfer and the result
// lands in a two-entry output queue, readable in the next cycle.
// in_ready drops only when both queue entries wait on out_ready.
// cfg_ready is always high; a write takes effect on the next tick.
// Reset loads the register defaults and clears all tick state and the queue.
module button_press_hold_and_encoder_events
    import bpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [NUM_BUTTONS-1:0] button_levels,
    input  logic [COUNT_WIDTH-1:0] encoder_count,
    input  logic                   clear_event,
    input  logic                   clear_status,
    input  logic                   clear_rotation,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   event_pending,
    output logic [STATUS_W-1:0]    button_status,
    output logic [ROT_W-1:0]       rotation,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    result_t tick_result;
    result_t q_data;
    logic    q_full;
    logic    in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LONG_PRESS: cfg_next.long_press_ticks = cfg_data;
                CFG_LOCKOUT:    cfg_next.lockout_ticks    = cfg_data;
                CFG_ENC_STEP:   cfg_next.encoder_step     = cfg_data[STEP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.lockout_ticks    <= LOCKOUT_RST;
            cfg_reg.encoder_step     <= ENC_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpe_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_xfer),
        .button_levels  (button_levels),
        .encoder_count  (encoder_count),
        .clear_event    (clear_event),
        .clear_status   (clear_status),
        .clear_rotation (clear_rotation),
        .cfg            (cfg_reg),
        .result         (tick_result)
    );

    bpe_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (tick_result),
        .pop_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (q_data),
        .full      (q_full)
    );

    assign event_pending = q_data.event_pending;
    assign button_status = q_data.button_status;
    assign rotation      = q_data.rotation;

    // A transfer in always leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick left no result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> button_status <= 4'd12)
        else $error("button status out of range");

    a_rotation_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rotation <= ROT_RIGHT)
        else $error("invalid rotation code");

endmodule

[tb/sv/button_press_hold_and_encoder_events_tb.sv]
// Testbench for the button press/hold and encoder event block, checked against its own predictor.
module button_press_hold_and_encoder_events_tb;
    import bpe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int REPORT_LINES = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [NUM_BUTTONS-1:0] button_levels = '1;
    logic [COUNT_WIDTH-1:0] encoder_count = '0;
    logic                   clear_event = 1'b0;
    logic                   clear_status = 1'b0;
    logic                   clear_rotation = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   event_pending;
    logic [STATUS_W-1:0]    button_status;
    logic [ROT_W-1:0]       rotation;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor registers and tick state
    logic [TIMER_W-1:0]     p_long_ticks = LONG_PRESS_RST;
    logic [TIMER_W-1:0]     p_lock_ticks = LOCKOUT_RST;
    logic [STEP_W-1:0]      p_enc_step = ENC_STEP_RST;
    logic [NUM_BUTTONS-1:0] p_prev_levels = '1;
    logic [NUM_BUTTONS-1:0] p_armed_release = '0;
    logic [TIMER_W-1:0]     p_lock_count = '0;
    logic                   p_lock_done = 1'b0;
    logic [TIMER_W-1:0]     p_hold_count = '0;
    logic                   p_hold_active = 1'b0;
    logic                   p_hold_done = 1'b0;
    logic [COUNT_WIDTH-1:0] p_enc_ref = '0;
    logic                   p_event = 1'b0;
    logic [STATUS_W-1:0]    p_status = STATUS_NONE;
    logic [ROT_W-1:0]       p_rot = ROT_NONE;

    result_t event_outputs_due[$];
    int      mismatch_count = 0;
    bit      idle_on = 1'b1;

    // Random press generator state
    logic [NUM_BUTTONS-1:0] cur_levels = '1;
    logic [COUNT_WIDTH-1:0] cur_count = '0;
    logic [NUM_BUTTONS-1:0] gen_holding = '0;
    bit                     gen_bounce = 1'b0;
    int                     gen_left = 0;

    button_press_hold_and_encoder_events i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_levels  (button_levels),
        .encoder_count  (encoder_count),
        .clear_event    (clear_event),
        .clear_status   (clear_status),
        .clear_rotation (clear_rotation),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_pending  (event_pending),
        .button_status  (button_status),
        .rotation       (rotation),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= !idle_on || ($urandom_range(99) >= 12);
    end

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] c);
        return (c == TIMER_MAX) ? c : c + 1'b1;
    endfunction

    // Advance the predictor by one tick and return the outputs it leaves.
    function automatic result_t next_event_outputs(
        input logic [NUM_BUTTONS-1:0] levels,
        input logic [COUNT_WIDTH-1:0] count,
        input logic                   clr_evt,
        input logic                   clr_stat,
        input logic                   clr_rot
    );
        result_t                res;
        logic                   lock_restart;
        logic                   hold_restart;
        logic                   taken;
        logic [COUNT_WIDTH-1:0] diff;
        logic [COUNT_WIDTH-1:0] back;
        lock_restart = 1'b0;
        hold_restart = 1'b0;
        taken = 1'b0;
        if (clr_evt)
            p_event = 1'b0;
        if (clr_stat)
            p_status = STATUS_NONE;
        if (clr_rot)
            p_rot = ROT_NONE;

        // Take at most one edge, lowest button first, only once the lockout ran out.
        if (p_lock_done)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (!taken)
                begin
                    if (!p_armed_release[i])
                    begin
                        if (p_prev_levels[i] && !levels[i])
                        begin
                            p_armed_release[i] = 1'b1;
                            hold_restart = 1'b1;
                            lock_restart = 1'b1;
                            taken = 1'b1;
                        end
                    end
                    else if (!p_prev_levels[i] && levels[i])
                    begin
                        p_armed_release[i] = 1'b0;
                        if (p_hold_done)
                        begin
                            p_hold_done = 1'b0;
                            p_status = STATUS_W'(2 * i + 2);
                        end
                        else
                        begin
                            p_status = STATUS_W'(2 * i + 1);
                        end
                        p_event = 1'b1;
                        lock_restart = 1'b1;
                        taken = 1'b1;
                    end
                end
            end
        end
        p_prev_levels = levels;

        if (lock_restart)
        begin
            p_lock_count = '0;
            p_lock_done = 1'b0;
        end
        else if (!p_lock_done)
        begin
            p_lock_count = sat_inc(p_lock_count);
            if (p_lock_count >= p_lock_ticks)
                p_lock_done = 1'b1;
        end

        if (hold_restart)
        begin
            p_hold_count = '0;
            p_hold_active = 1'b1;
            p_hold_done = 1'b0;
        end
        else if (p_hold_active)
        begin
            p_hold_count = sat_inc(p_hold_count);
            if (p_hold_count >= p_long_ticks)
            begin
                p_hold_done = 1'b1;
                p_hold_active = 1'b0;
            end
        end

        diff = count - p_enc_ref;
        if (diff != '0)
        begin
            if (!diff[COUNT_WIDTH-1])
            begin
                if (diff >= COUNT_WIDTH'(p_enc_step))
                begin
                    p_rot = ROT_RIGHT;
                    p_event = 1'b1;
                    p_enc_ref = count;
                end
            end
            else
            begin
                back = -diff;
                if (back >= COUNT_WIDTH'(p_enc_step))
                begin
                    p_rot = ROT_LEFT;
                    p_event = 1'b1;
                    p_enc_ref = count;
                end
            end
        end

        res.event_pending = p_event;
        res.button_status = p_status;
        res.rotation = p_rot;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (mismatch_count < REPORT_LINES)
            $display("mismatch on %s at %0t, want %0h got %0h", what, $realtime, want, got);
        mismatch_count++;
    endtask

    // Compare each output transfer with the oldest predicted tick.
    always @(negedge clk)
    begin : check_outputs
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (event_outputs_due.size() == 0)
            begin
                flag_mismatch("transfer with no tick waiting", 16'h0, 16'h0);
            end
            else
            begin
                want = event_outputs_due.pop_front();
                if (event_pending !== want.event_pending)
                    flag_mismatch("event_pending", 16'(want.event_pending),
                                  16'(event_pending));
                if (button_status !== want.button_status)
                    flag_mismatch("button_status", 16'(want.button_status),
                                  16'(button_status));
                if (rotation !== want.rotation)
                    flag_mismatch("rotation", 16'(want.rotation), 16'(rotation));
            end
        end
    end

    task automatic send_tick(
        input logic [NUM_BUTTONS-1:0] levels,
        input logic [COUNT_WIDTH-1:0] count,
        input logic                   clr_evt,
        input logic                   clr_stat,
        input logic                   clr_rot
    );
        logic took;
        while (idle_on && ($urandom_range(99) < 12))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        button_levels <= levels;
        encoder_count <= count;
        clear_event <= clr_evt;
        clear_status <= clr_stat;
        clear_rotation <= clr_rot;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        event_outputs_due.push_back(next_event_outputs(levels, count, clr_evt, clr_stat,
                                                       clr_rot));
    endtask

    // Drop valid and wait until every predicted tick has been read out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (event_outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LONG_PRESS: p_long_ticks = data;
            CFG_LOCKOUT:    p_lock_ticks = data;
            CFG_ENC_STEP:   p_enc_step = data[STEP_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle_and_configure(input logic [TIMER_W-1:0] long_ticks,
                                        input logic [TIMER_W-1:0] lock_ticks,
                                        input logic [STEP_W-1:0] step);
        wait_idle();
        program_register(CFG_LONG_PRESS, long_ticks);
        program_register(CFG_LOCKOUT, lock_ticks);
        // Upper data bits are junk for the step register.
        program_register(CFG_ENC_STEP, {8'($urandom_range(0, 255)), step});
    endtask

    // Defaults after reset: encoder thresholds and a press inside the initial lockout.
    task automatic test_encoder_defaults();
        send_tick(6'h3F, 16'h0004, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3E, 16'h0001, 1'b1, 1'b0, 1'b0);
        send_tick(6'h3F, 16'hFFFD, 1'b0, 1'b0, 1'b1);
    endtask

    // Zero registers act as one; simultaneous presses, lost edges, the hold of the last button.
    task automatic test_zero_registers();
        wait_idle();
        program_register(CFG_LONG_PRESS, 16'h0000);
        program_register(CFG_LOCKOUT, 16'h0000);
        program_register(CFG_ENC_STEP, 16'h0000);
        send_tick(6'h3F, 16'hFFFD, 1'b1, 1'b1, 1'b1);
        send_tick(6'h1E, 16'hFFFE, 1'b0, 1'b0, 1'b0);
        send_tick(6'h1E, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_tick(6'h1F, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3F, 16'h8000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3F, 16'h8000, 1'b0, 1'b1, 1'b1);
        send_tick(6'h1F, 16'h8000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3F, 16'h8000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h1F, 16'h8000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3F, 16'h8000, 1'b0, 1'b0, 1'b0);
    endtask

    // Largest register values, step masking and the unmapped index.
    task automatic test_register_extremes();
        wait_idle();
        program_register(CFG_LONG_PRESS, 16'hFFFF);
        program_register(CFG_LOCKOUT, 16'h0001);
        program_register(CFG_ENC_STEP, 16'hFFFF);
        program_register(CFG_UNUSED, 16'h0055);
        send_tick(6'h3F, 16'h80FF, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3B, 16'h81FD, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3B, 16'h8000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3F, 16'h8000, 1'b0, 1'b0, 1'b0);
        wait_idle();
        program_register(CFG_LOCKOUT, 16'hFFFF);
        send_tick(6'h3E, 16'h8000, 1'b0, 1'b0, 1'b0);
        send_tick(6'h3F, 16'h8000, 1'b0, 1'b0, 1'b0);
        cur_count = 16'h8000;
    endtask

    task automatic run_random_ticks(input int count);
        int                     span_long;
        int                     span_lock;
        int                     r;
        int                     b;
        logic [COUNT_WIDTH-1:0] delta;
        span_long = (p_long_ticks > 40) ? 40 : ((p_long_ticks == 0) ? 1 : p_long_ticks);
        span_lock = (p_lock_ticks > 20) ? 20 : p_lock_ticks;
        for (int n = 0; n < count; n++)
        begin
            if (gen_left == 0)
            begin
                if (gen_bounce)
                begin
                    cur_levels = '1;
                    gen_bounce = 1'b0;
                    gen_left = $urandom_range(0, 3);
                end
                else if (gen_holding != '0)
                begin
                    // Release the lowest held button; the gap may fall short of the lockout.
                    cur_levels = cur_levels | (gen_holding & -gen_holding);
                    gen_holding = gen_holding & (gen_holding - 1'b1);
                    gen_left = span_lock + $urandom_range(0, 3) - $urandom_range(0, 2);
                    if (gen_left < 0)
                        gen_left = 0;
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 65)
                    begin
                        b = $urandom_range(0, NUM_BUTTONS - 1);
                        gen_holding = NUM_BUTTONS'(1) << b;
                    end
                    else if (r < 78)
                    begin
                        b = $urandom_range(0, NUM_BUTTONS - 1);
                        gen_holding = NUM_BUTTONS'(1) << b;
                        b = $urandom_range(0, NUM_BUTTONS - 1);
                        gen_holding = gen_holding | (NUM_BUTTONS'(1) << b);
                    end
                    if (r < 78)
                    begin
                        cur_levels = cur_levels & ~gen_holding;
                        if ($urandom_range(1))
                            gen_left = $urandom_range(1, span_long);
                        else
                            gen_left = $urandom_range(span_long, span_long + span_lock + 4);
                    end
                    else if (r < 90)
                    begin
                        cur_levels = NUM_BUTTONS'($urandom_range(0, 63));
                        gen_bounce = 1'b1;
                        gen_left = 1;
                    end
                    else
                    begin
                        gen_left = $urandom_range(1, 6);
                    end
                end
            end

            r = $urandom_range(99);
            if (r < 45)
                delta = '0;
            else if (r < 65)
                delta = COUNT_WIDTH'(p_enc_step);
            else if (r < 80)
                delta = COUNT_WIDTH'($urandom_range(0, p_enc_step + 2));
            else if (r < 90)
                delta = COUNT_WIDTH'($urandom);
            else
                delta = (p_enc_step == 0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(p_enc_step - 1);
            if ($urandom_range(1))
                cur_count = cur_count - delta;
            else
                cur_count = cur_count + delta;

            send_tick(cur_levels, cur_count, $urandom_range(99) < 15,
                      $urandom_range(99) < 15, $urandom_range(99) < 15);
            if (gen_left > 0)
                gen_left--;
        end
    endtask

    task automatic test_random_press_sequences();
        settle_and_configure(TIMER_W'($urandom_range(2, 20)), TIMER_W'($urandom_range(1, 4)),
                             STEP_W'($urandom_range(1, 6)));
        run_random_ticks(130);
        settle_and_configure(16'd1, 16'd1, 8'd1);
        run_random_ticks(110);
        // Long stretch with both sides always ready
        idle_on = 1'b0;
        settle_and_configure(TIMER_W'($urandom_range(3, 25)), TIMER_W'($urandom_range(1, 6)),
                             STEP_W'($urandom_range(1, 8)));
        run_random_ticks(130);
        idle_on = 1'b1;
        settle_and_configure(TIMER_W'($urandom_range(5, 40)), TIMER_W'($urandom_range(5, 15)),
                             STEP_W'($urandom_range(2, 8)));
        run_random_ticks(130);
        settle_and_configure(TIMER_W'($urandom_range(1, 30)), TIMER_W'($urandom_range(1, 8)),
                             STEP_W'($urandom_range(9, 255)));
        run_random_ticks(130);
        settle_and_configure(TIMER_W'($urandom_range(2, 12)), TIMER_W'($urandom_range(1, 3)),
                             STEP_W'($urandom_range(1, 4)));
        run_random_ticks(120);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encoder_defaults();
        test_zero_registers();
        test_register_extremes();
        test_random_press_sequences();
        wait_idle();
        if (mismatch_count == 0 && event_outputs_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
